// File: rtl/core/ptl_pkg.sv
// ptl_pkg: shared constants, register codes and pipeline types for pixel_to_luma
// no dependencies; used by rtl/core/pixel_to_luma.sv

package ptl_pkg;

  // pixel word and result widths
  localparam int WordW     = 32;
  localparam int LumaW     = 8;
  localparam int PixelBits = 32;
  localparam logic [WordW-1:0] PixelMask =
    (PixelBits >= WordW) ? {WordW{1'b1}} : WordW'((64'd1 << PixelBits) - 64'd1);

  // channel geometry
  localparam int NumCh  = 3;
  localparam int ShiftW = $clog2(WordW);
  localparam int BitsW  = $clog2(WordW + 1);
  localparam logic [BitsW-1:0] NativeBits = BitsW'(8);

  // divider shape: dividend is value*255, so eight bits above the word
  localparam int DvdW      = WordW + 8;
  localparam int StepBits  = 4;
  localparam int DivStages = DvdW / StepBits;
  // only bits 15:8 of the weighted sum are kept, so 16 quotient bits suffice
  localparam int QuoW      = 16;

  // rec.601 weights
  localparam logic [7:0] WeightR = 8'd77;
  localparam logic [7:0] WeightG = 8'd150;
  localparam logic [7:0] WeightB = 8'd29;

  // configuration register indexes
  localparam int CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] RegRedMask   = 2'd0;
  localparam logic [CfgAddrW-1:0] RegGreenMask = 2'd1;
  localparam logic [CfgAddrW-1:0] RegBlueMask  = 2'd2;

  localparam logic [WordW-1:0] RedMaskRst   = 32'h00FF_0000;
  localparam logic [WordW-1:0] GreenMaskRst = 32'h0000_FF00;
  localparam logic [WordW-1:0] BlueMaskRst  = 32'h0000_00FF;

  // one channel as it moves through the divider
  typedef struct packed {
    logic [WordW-1:0] rem;
    logic [DvdW-1:0]  dvd;
    logic [WordW-1:0] dsr;
    logic [QuoW-1:0]  quo;
  } div_lane_t;

  // palette flag and pass-through byte that ride along with every beat
  typedef struct packed {
    logic             pal;
    logic [LumaW-1:0] low_byte;
  } ctl_t;

endpackage

// File: rtl/core/pixel_to_luma.sv
// pixel_to_luma: packed pixel word to 8-bit rec.601 luma, fully pipelined
// depends on rtl/core/ptl_pkg.sv

// One pixel beat in, one luma beat out, one beat per clock sustained while
// the output is not stalled. The path is 13 register stages: one stage for
// masking, trailing-zero count and popcount, one for the field shift and
// divisor setup, ten stages of a 40-bit restoring divider that retires 4
// quotient bits per stage (this divider sets the depth), and one stage for
// the weighted sum. Each channel is rescaled as value*255/(2^bits-1) unless
// its mask has 8 or 0 bits set; when all three masks are zero the low byte
// of the pixel passes through. Stalls on the output side back up through the
// stages without losing or repeating a beat. Masks are written on the plain
// cfg port and must only change while the pipeline is empty.

module pixel_to_luma (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [ptl_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [ptl_pkg::WordW-1:0]      cfg_wdata_i,
  // pixel stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ptl_pkg::WordW-1:0]      s_axis_tdata,   // [31:0] pixel_word
  // luma stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ptl_pkg::LumaW-1:0]      m_axis_tdata    // [7:0] luma
);

  localparam int NumCh     = ptl_pkg::NumCh;
  localparam int DivStages = ptl_pkg::DivStages;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [ptl_pkg::WordW-1:0] mask_q [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q[0] <= ptl_pkg::RedMaskRst;
      mask_q[1] <= ptl_pkg::GreenMaskRst;
      mask_q[2] <= ptl_pkg::BlueMaskRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ptl_pkg::RegRedMask:   mask_q[0] <= cfg_wdata_i;
        ptl_pkg::RegGreenMask: mask_q[1] <= cfg_wdata_i;
        ptl_pkg::RegBlueMask:  mask_q[2] <= cfg_wdata_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------
  // trailing zero count, zero for an empty mask
  function automatic logic [ptl_pkg::ShiftW-1:0] trail_zeros(
    input logic [ptl_pkg::WordW-1:0] m
  );
    logic [ptl_pkg::ShiftW-1:0] n;
    n = '0;
    for (int i = ptl_pkg::WordW - 1; i >= 0; i--) begin
      if (m[i]) n = ptl_pkg::ShiftW'(i);
    end
    return n;
  endfunction

  function automatic logic [ptl_pkg::BitsW-1:0] ones_cnt(
    input logic [ptl_pkg::WordW-1:0] m
  );
    logic [ptl_pkg::BitsW-1:0] n;
    n = '0;
    for (int i = 0; i < ptl_pkg::WordW; i++) begin
      n = n + ptl_pkg::BitsW'(m[i]);
    end
    return n;
  endfunction

  // StepBits restoring division steps, msb of the dividend first
  function automatic ptl_pkg::div_lane_t div_step(input ptl_pkg::div_lane_t l);
    ptl_pkg::div_lane_t       o;
    logic [ptl_pkg::WordW:0]  r;
    logic                     qb;
    o = l;
    for (int i = 0; i < ptl_pkg::StepBits; i++) begin
      r     = {o.rem, o.dvd[ptl_pkg::DvdW-1]};
      o.dvd = {o.dvd[ptl_pkg::DvdW-2:0], 1'b0};
      qb    = (r >= {1'b0, o.dsr});
      if (qb) r = r - {1'b0, o.dsr};
      o.rem = r[ptl_pkg::WordW-1:0];
      o.quo = {o.quo[ptl_pkg::QuoW-2:0], qb};
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // stage valids and enables: a stage moves when it is empty or the
  // stage after it moves
  // ---------------------------------------------------------------------
  logic                 a_vld_q, b_vld_q, out_vld_q;
  logic [DivStages-1:0] d_vld_q;
  logic                 en_a, en_b, en_out;
  logic [DivStages-1:0] en_d;

  always_comb begin
    en_out              = !out_vld_q || m_axis_tready;
    en_d[DivStages-1]   = !d_vld_q[DivStages-1] || en_out;
    for (int k = DivStages - 2; k >= 0; k--) begin
      en_d[k] = !d_vld_q[k] || en_d[k+1];
    end
    en_b = !b_vld_q || en_d[0];
    en_a = !a_vld_q || en_b;
  end

  assign s_axis_tready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      d_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= s_axis_tvalid;
      if (en_b) b_vld_q <= a_vld_q;
      if (en_d[0]) d_vld_q[0] <= b_vld_q;
      for (int k = 1; k < DivStages; k++) begin
        if (en_d[k]) d_vld_q[k] <= d_vld_q[k-1];
      end
      if (en_out) out_vld_q <= d_vld_q[DivStages-1];
    end
  end

  // ---------------------------------------------------------------------
  // stage a: mask, trailing zeros, popcount
  // ---------------------------------------------------------------------
  logic [ptl_pkg::WordW-1:0]  a_pm_d [NumCh], a_pm_q [NumCh];
  logic [ptl_pkg::ShiftW-1:0] a_tz_d [NumCh], a_tz_q [NumCh];
  logic [ptl_pkg::BitsW-1:0]  a_bits_d [NumCh], a_bits_q [NumCh];
  ptl_pkg::ctl_t              a_ctl_d, a_ctl_q;

  always_comb begin
    logic [ptl_pkg::WordW-1:0] pix;
    logic [ptl_pkg::WordW-1:0] m;
    logic                      any;
    pix = s_axis_tdata & ptl_pkg::PixelMask;
    any = 1'b0;
    for (int c = 0; c < NumCh; c++) begin
      m           = mask_q[c] & ptl_pkg::PixelMask;
      any         = any | (|m);
      a_pm_d[c]   = pix & m;
      a_tz_d[c]   = trail_zeros(m);
      a_bits_d[c] = ones_cnt(m);
    end
    a_ctl_d.pal      = !any;
    a_ctl_d.low_byte = pix[ptl_pkg::LumaW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_pm_q   <= a_pm_d;
      a_tz_q   <= a_tz_d;
      a_bits_q <= a_bits_d;
      a_ctl_q  <= a_ctl_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage b: field shift, dividend and divisor; 8-bit and empty channels
  // divide by one so they pass unscaled
  // ---------------------------------------------------------------------
  ptl_pkg::div_lane_t b_lane_d [NumCh], b_lane_q [NumCh];
  ptl_pkg::ctl_t      b_ctl_q;

  always_comb begin
    logic [ptl_pkg::WordW-1:0] v;
    logic                      bypass;
    for (int c = 0; c < NumCh; c++) begin
      v      = a_pm_q[c] >> a_tz_q[c];
      bypass = (a_bits_q[c] == ptl_pkg::NativeBits) || (a_bits_q[c] == '0);
      b_lane_d[c].rem = '0;
      b_lane_d[c].quo = '0;
      if (bypass) begin
        b_lane_d[c].dvd = {8'd0, v};
        b_lane_d[c].dsr = ptl_pkg::WordW'(1);
      end else begin
        // v*255 as v*256 - v
        b_lane_d[c].dvd = {v, 8'd0} - {8'd0, v};
        b_lane_d[c].dsr = ptl_pkg::WordW'(
          ({1'b0, {ptl_pkg::WordW{1'b0}}} | (33'd1 << a_bits_q[c])) - 33'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_lane_q <= b_lane_d;
      b_ctl_q  <= a_ctl_q;
    end
  end

  // ---------------------------------------------------------------------
  // divider stages
  // ---------------------------------------------------------------------
  ptl_pkg::div_lane_t d_lane_q [DivStages][NumCh];
  ptl_pkg::ctl_t      d_ctl_q  [DivStages];

  always_ff @(posedge clk_i) begin
    if (en_d[0]) begin
      for (int c = 0; c < NumCh; c++) begin
        d_lane_q[0][c] <= div_step(b_lane_q[c]);
      end
      d_ctl_q[0] <= b_ctl_q;
    end
    for (int k = 1; k < DivStages; k++) begin
      if (en_d[k]) begin
        for (int c = 0; c < NumCh; c++) begin
          d_lane_q[k][c] <= div_step(d_lane_q[k-1][c]);
        end
        d_ctl_q[k] <= d_ctl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // output stage: weighted sum, only bits 15:8 survive
  // ---------------------------------------------------------------------
  logic [ptl_pkg::LumaW-1:0] luma_d, luma_q;

  always_comb begin
    logic [ptl_pkg::QuoW+7:0] pr, pg, pb;
    logic [ptl_pkg::QuoW-1:0] sum;
    pr  = d_lane_q[DivStages-1][0].quo * ptl_pkg::WeightR;
    pg  = d_lane_q[DivStages-1][1].quo * ptl_pkg::WeightG;
    pb  = d_lane_q[DivStages-1][2].quo * ptl_pkg::WeightB;
    sum = pr[ptl_pkg::QuoW-1:0] + pg[ptl_pkg::QuoW-1:0] + pb[ptl_pkg::QuoW-1:0];
    if (d_ctl_q[DivStages-1].pal) luma_d = d_ctl_q[DivStages-1].low_byte;
    else                          luma_d = sum[15:8];
  end

  always_ff @(posedge clk_i) begin
    if (en_out) luma_q <= luma_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = luma_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // input only backs up when the output register is full and stalled
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_vld_q && !m_axis_tready))
    else $error("input stalled without an output stall");

  // divisor is never zero once a beat is set up
  a_dsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> ((b_lane_q[0].dsr != '0) && (b_lane_q[1].dsr != '0)
                 && (b_lane_q[2].dsr != '0)))
    else $error("zero divisor in setup stage");

  // partial remainder stays below the divisor at the last divider stage
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q[DivStages-1] |->
      ((d_lane_q[DivStages-1][0].rem < d_lane_q[DivStages-1][0].dsr)
       && (d_lane_q[DivStages-1][1].rem < d_lane_q[DivStages-1][1].dsr)
       && (d_lane_q[DivStages-1][2].rem < d_lane_q[DivStages-1][2].dsr)))
    else $error("divider remainder out of range");

  // palette beats carry the raw low byte to the output
  a_palette_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_out && d_vld_q[DivStages-1] && d_ctl_q[DivStages-1].pal) |=>
      (m_axis_tdata == $past(d_ctl_q[DivStages-1].low_byte)))
    else $error("palette byte not passed through");

endmodule
